@@ rtl/accel_tilt_deviation_assert.svh @@
// Assertion macros for the tilt deviation block.
// Included by the top level; no other dependencies.
`ifndef ACCEL_TILT_DEVIATION_ASSERT_SVH
`define ACCEL_TILT_DEVIATION_ASSERT_SVH
// implication checked every clock outside reset
`define ATD_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define ATD_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ rtl/atd_pkg.sv @@
// Shared types and constants for the tilt deviation block.
// No dependencies.
package atd_pkg;
  localparam int TabLen = 24;
  localparam logic [16:0] AngFull = 17'd46080;
  localparam logic [16:0] DeadBand = 17'd640;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CAL, ST_FILT, ST_CORD, ST_FIN, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    REG_CAL_X = 3'd0, REG_CAL_Y = 3'd1, REG_CAL_Z = 3'd2, REG_FF = 3'd3,
    REG_FB = 3'd4, REG_TROLL = 3'd5, REG_TPITCH = 3'd6, REG_OPER = 3'd7
  } reg_idx_t;

  // lane control from the sequencer
  typedef struct packed {
    logic start;
    logic step;
  } lane_ctl_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [21:0] atan_tab(input logic [4:0] i);
    unique case (i)
      5'd0: return 22'd2949120; 5'd1: return 22'd1740967;
      5'd2: return 22'd919879; 5'd3: return 22'd466945;
      5'd4: return 22'd234379; 5'd5: return 22'd117304;
      5'd6: return 22'd58666; 5'd7: return 22'd29335;
      5'd8: return 22'd14668; 5'd9: return 22'd7334;
      5'd10: return 22'd3667; 5'd11: return 22'd1833;
      5'd12: return 22'd917; 5'd13: return 22'd458;
      5'd14: return 22'd229; 5'd15: return 22'd115;
      5'd16: return 22'd57; 5'd17: return 22'd29;
      5'd18: return 22'd14; 5'd19: return 22'd7;
      5'd20: return 22'd4; 5'd21: return 22'd2;
      5'd22: return 22'd1;
      default: return 22'd0;
    endcase
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) return 24'sd8388607;
    if (v < -48'sd8388608) return -24'sd8388608;
    return v[23:0];
  endfunction
endpackage

@@ rtl/atd_axis_lane.sv @@
// One axis lane: calibration row and biquad with its four history registers.
// Depends on atd_pkg.
module atd_axis_lane (
  input  logic                   clk,
  input  logic                   rst,
  input  atd_pkg::lane_ctl_t     ctl,
  input  logic signed [15:0]     ax,
  input  logic signed [15:0]     ay,
  input  logic signed [15:0]     az,
  input  logic [63:0]            row,
  input  logic [47:0]            ff,
  input  logic [31:0]            fb,
  output logic signed [23:0]     filt
);
  import atd_pkg::*;

  logic signed [31:0] p0, p1, p2;
  logic signed [23:0] cal;
  logic signed [23:0] x1, x2, y1, y2;
  logic signed [39:0] q0, q1, q2, q3, q4;
  logic signed [47:0] csum, fsum;

  // calibration products (registered before summing)
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      p0 <= ax * $signed(row[15:0]);
      p1 <= ay * $signed(row[31:16]);
      p2 <= az * $signed(row[47:32]);
    end
  end

  always_comb begin
    csum = 48'(p0) + 48'(p1) + 48'(p2) + (48'($signed(row[63:48])) <<< 12) + 48'sd2048;
    fsum = 48'(q0) + 48'(q1) + 48'(q2) + 48'(q3) + 48'(q4) + 48'sd8192;
  end

  // round, saturate, then filter products
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      cal <= sat24(csum >>> 12);
    end
  end

  logic fstage;
  always_ff @(posedge clk) begin
    if (rst) begin
      fstage <= 1'b0;
    end else begin
      fstage <= ctl.step;
    end
  end

  always_ff @(posedge clk) begin
    if (fstage) begin
      q0 <= cal * $signed(ff[15:0]);
      q1 <= x1 * $signed(ff[31:16]);
      q2 <= x2 * $signed(ff[47:32]);
      q3 <= y1 * $signed(fb[15:0]);
      q4 <= y2 * $signed(fb[31:16]);
    end
  end

  logic fdone;
  always_ff @(posedge clk) begin
    if (rst) begin
      fdone <= 1'b0;
    end else begin
      fdone <= fstage;
    end
  end

  // advance filter history
  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0; x2 <= '0; y1 <= '0; y2 <= '0; filt <= '0;
    end else if (fdone) begin
      filt <= sat24(fsum >>> 14);
      y1 <= sat24(fsum >>> 14);
      y2 <= y1;
      x1 <= cal;
      x2 <= x1;
    end
  end
endmodule

@@ rtl/atd_cordic.sv @@
// Iterative CORDIC vectoring unit giving atan2 in 1/128 degree.
// Depends on atd_pkg.
module atd_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [24:0] num,
  input  logic signed [23:0] den,
  output logic               done,
  output logic [15:0]        angle
);
  import atd_pkg::*;

  localparam int CW = $clog2(TabLen + 1);
  localparam int NS = (STEPS < TabLen) ? STEPS : TabLen;
  localparam logic signed [31:0] Full = 32'(AngFull);

  logic signed [35:0] x, y;
  logic signed [31:0] z;
  logic [CW-1:0] i;
  logic busy, zero;
  logic signed [35:0] xs, ys, xn, yn;
  logic signed [31:0] zr, t;
  logic signed [24:0] nn, dn;

  always_comb begin
    xs = x >>> i;
    ys = y >>> i;
    nn = num;
    dn = 25'(den);
    zr = (z + 32'sd256) >>> 9;
    t = zr;
    if (t < 0) t = t + Full;
    if (t >= Full) t = t - Full;
  end

  // iterate one rotation per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0; i <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; i <= '0;
        zero <= (num == 0) && (den == 0);
        if (den < 0) begin
          x <= -(36'(dn) <<< 8); y <= -(36'(nn) <<< 8); z <= 32'sd11796480;
        end else begin
          x <= 36'(dn) <<< 8; y <= 36'(nn) <<< 8; z <= '0;
        end
      end else if (busy) begin
        if (i == CW'(NS)) begin
          busy <= 1'b0; done <= 1'b1;
          angle <= zero ? 16'd0 : t[15:0];
        end else begin
          i <= i + 1'b1;
          if (y >= 0) begin
            x <= x + ys; y <= y - xs; z <= z + 32'(atan_tab(5'(i)));
          end else begin
            x <= x - ys; y <= y + xs; z <= z - 32'(atan_tab(5'(i)));
          end
        end
      end
    end
  end
endmodule

@@ rtl/accel_tilt_deviation.sv @@
// Top level of the tilt deviation block: registers, sequencer, lanes, merge.
// Depends on atd_pkg, atd_axis_lane, atd_cordic and the assertion header.
//
// Usage: samples enter on s_axis (tdata = accel_x, accel_y, accel_z, 16 bits
// each from bit 0). Results leave on m_axis, one per sample. Three axis lanes
// calibrate and filter in parallel; two CORDIC units then resolve roll and
// pitch together, then the merge registers the deviations and the output
// register takes the result; one sample is in work at a time. The result
// holds in the output register while m_axis_tready is low; the next sample is
// taken once it leaves.
// Reset (rst, synchronous) restores register defaults and clears the filter
// history and the output valid. Configuration is written with cfg_we,
// cfg_index and cfg_data while idle.
`include "accel_tilt_deviation_assert.svh"
module accel_tilt_deviation #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // filtered_x, filtered_y, filtered_z (24 each), roll_angle, pitch_angle,
  // roll_deviation, pitch_deviation (16 each)
  output logic [135:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import atd_pkg::*;

  logic [63:0] cal_x, cal_y, cal_z;
  logic [47:0] ff;
  logic [31:0] fb;
  logic [8:0] troll, tpitch;
  logic oper;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_x <= 64'd4096; cal_y <= 64'd268435456; cal_z <= 64'd17592186044416;
      ff <= 48'd16384; fb <= '0; troll <= '0; tpitch <= '0; oper <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CAL_X: cal_x <= cfg_data;
        REG_CAL_Y: cal_y <= cfg_data;
        REG_CAL_Z: cal_z <= cfg_data;
        REG_FF: ff <= cfg_data[47:0];
        REG_FB: fb <= cfg_data[31:0];
        REG_TROLL: troll <= cfg_data[8:0];
        REG_TPITCH: tpitch <= cfg_data[8:0];
        REG_OPER: oper <= cfg_data[0];
      endcase
    end
  end

  state_t state, state_next;
  logic [1:0] cnt, cnt_next;
  lane_ctl_t ctl;
  logic cstart;
  logic rdone, pdone;
  logic [15:0] roll, pitch;
  logic signed [23:0] fx, fy, fz;
  logic s_acc;
  logic signed [15:0] ax, ay, az;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign ax = s_axis_tdata[15:0];
  assign ay = s_axis_tdata[31:16];
  assign az = s_axis_tdata[47:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; cnt <= '0;
    end else begin
      state <= state_next; cnt <= cnt_next;
    end
  end

  // sequence one sample through lanes, CORDIC and merge
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    s_axis_tready = 1'b0;
    ctl = '0;
    cstart = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = !m_axis_tvalid;
        ctl.start = s_acc;
        if (s_acc) state_next = ST_CAL;
      end
      ST_CAL: begin
        ctl.step = 1'b1; cnt_next = '0; state_next = ST_FILT;
      end
      ST_FILT: begin
        cnt_next = cnt + 1'b1;
        if (cnt == 2'd2) begin
          cstart = 1'b1; state_next = ST_CORD;
        end
      end
      ST_CORD: if (rdone) state_next = ST_FIN;
      ST_FIN: state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  atd_axis_lane u_lx (.clk, .rst, .ctl, .ax, .ay, .az, .row(cal_x), .ff, .fb,
                      .filt(fx));
  atd_axis_lane u_ly (.clk, .rst, .ctl, .ax, .ay, .az, .row(cal_y), .ff, .fb,
                      .filt(fy));
  atd_axis_lane u_lz (.clk, .rst, .ctl, .ax, .ay, .az, .row(cal_z), .ff, .fb,
                      .filt(fz));

  // negated x needs 25 bits to hold the full-scale negative value
  atd_cordic #(.STEPS(CORDIC_STEPS)) u_roll (.clk, .rst, .start(cstart),
    .num(-25'(fx)), .den(fz), .done(rdone), .angle(roll));
  atd_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (.clk, .rst, .start(cstart),
    .num(25'(fy)), .den(fz), .done(pdone), .angle(pitch));

  // merge: deviations registered, then output
  logic [16:0] rd, pd;
  logic [15:0] rdev, pdev;
  always_comb begin
    rd = ({1'b0, roll} >= {troll, 7'd0}) ? 17'({1'b0, roll} - {troll, 7'd0})
                                        : 17'({troll, 7'd0} - {1'b0, roll});
    pd = ({1'b0, pitch} >= {tpitch, 7'd0}) ? 17'({1'b0, pitch} - {tpitch, 7'd0})
                                          : 17'({tpitch, 7'd0} - {1'b0, pitch});
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN) begin
      rdev <= (rd < DeadBand || !oper) ? 16'd0 : rd[15:0];
      pdev <= (pd < DeadBand || !oper) ? 16'd0 : pd[15:0];
    end
  end

  // hold result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_OUT) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata <= {pdev, rdev, pitch, roll, fz, fy, fx};
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  `ATD_ASSERT_IMP(a_cordic_pair, clk, rst, rdone, pdone)
  `ATD_ASSERT_IMP(a_no_accept_busy, clk, rst, state != ST_IDLE, !s_axis_tready)
  `ATD_ASSERT_NEXT(a_out_valid, clk, rst, state == ST_OUT, m_axis_tvalid)
endmodule
